### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and codes for the first-fit heap allocator
// Status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE  = 2'd0,
    CFG_HEAP_LIMIT = 2'd1
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

endpackage

### rtl/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator over a block table
// Walk: table entries are examined from entry 0 until a hit or the end of the
//   table, so between 0 and the block count entries are passed over. One table
//   entry is examined per cycle through the registered read port of the block
//   RAM and the address adder.
// Throughput: one request at a time; busy_o drops in the cycle the result
//   is shown, so the next start can be taken then. Results cannot be stalled.
// Reset: table empty, used count zero, registers at their defaults, no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS   = 256,
  parameter int unsigned HEADER_BYTES = 8,
  parameter int unsigned GAP_BYTES    = 4,
  parameter int unsigned ADDR_BITS    = 22
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request command
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           mode_i,
  input  logic [ADDR_BITS-1:0]           req_size_i,
  input  logic [ADDR_BITS-1:0]           address_i,
  // result strobe
  output logic                           valid_o,
  output logic [ffha_pkg::STATUS_W-1:0]  status_o,
  output logic [ADDR_BITS-1:0]           result_address_o,
  output logic [ADDR_BITS-1:0]           bytes_used_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_BITS-1:0]           cfg_data_i
);

  import ffha_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);  // block count, holds MAX_BLOCKS
  localparam int unsigned IW = $clog2(MAX_BLOCKS);      // table index
  localparam int unsigned XW = AW + 2;                  // sums taken without wrap

  localparam logic [XW-1:0] HDR     = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] HDR_GAP = XW'(HEADER_BYTES + GAP_BYTES);
  localparam logic [CW-1:0] FULL    = CW'(MAX_BLOCKS);

  localparam logic [AW-1:0] BASE_RST  = AW'(1052672);
  localparam logic [AW-1:0] LIMIT_RST = AW'(4063232);

  // Clamp a grown sum to the all-ones address value.
  function automatic logic [AW-1:0] sat_top(input logic [XW-1:0] s);
    logic [AW-1:0] r;
    r = (s[XW-1:AW] != 2'b00) ? {AW{1'b1}} : s[AW-1:0];
    return r;
  endfunction

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] limit_q, limit_d;
  logic [AW-1:0] next_q, next_d;
  logic [AW-1:0] used_q, used_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] at_q, at_d;
  logic          mode_q, mode_d;
  logic [AW-1:0] req_q, req_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          valid_q, valid_d;
  status_e       status_q, status_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic [AW-1:0] bytes_q, bytes_d;

  // block RAM: {in_use, size}
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [AW:0]   ram_wdata;
  logic [AW:0]   ram_rdata;

  ffha_ram #(
    .WIDTH (AW + 1),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Entry under test: read data always belongs to idx_q during the walk.
  logic          ent_used;
  logic [AW-1:0] ent_size;
  logic [AW-1:0] pay_addr;
  logic [AW-1:0] at_step;
  logic          in_range;
  logic          alloc_hit;
  logic          free_hit;

  assign ent_used  = ram_rdata[AW];
  assign ent_size  = ram_rdata[AW-1:0];
  assign pay_addr  = at_q + HDR[AW-1:0];
  assign at_step   = at_q + ent_size + HDR_GAP[AW-1:0];
  assign in_range  = (idx_q < count_q);
  assign alloc_hit = !ent_used && (ent_size >= req_q);
  assign free_hit  = (pay_addr == addr_q);

  // Append and bookkeeping sums, all without wrap.
  logic [XW-1:0] oom_sum;
  logic [XW-1:0] app_len;
  logic [XW-1:0] next_sum;
  logic [XW-1:0] used_app_sum;
  logic [XW-1:0] used_reuse_sum;
  logic [XW-1:0] rel_len;
  logic          oom;

  assign oom_sum        = {2'b00, next_q} + {2'b00, req_q} + HDR;
  assign oom            = (oom_sum >= {2'b00, limit_q});
  assign app_len        = {2'b00, req_q} + HDR_GAP;
  assign next_sum       = {2'b00, next_q} + app_len;
  assign used_app_sum   = {2'b00, used_q} + app_len;
  assign used_reuse_sum = {2'b00, used_q} + {2'b00, req_q} + HDR;
  assign rel_len        = {2'b00, ent_size} + HDR;

  logic cfg_wr;
  logic fin;

  // Take register writes only while idle and no start is offered.
  assign cfg_ready_o = (state_q == S_IDLE) && !start_i;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    limit_d    = limit_q;
    next_d     = next_q;
    used_d     = used_q;
    count_d    = count_q;
    idx_d      = idx_q;
    at_d       = at_q;
    mode_d     = mode_q;
    req_d      = req_q;
    addr_d     = addr_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    res_addr_d = res_addr_q;
    bytes_d    = bytes_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q[IW-1:0];
    ram_wdata  = {1'b1, ent_size};
    fin        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cfg_wr) begin
          case (cfg_index_i)
            CFG_HEAP_BASE: begin
              base_d = cfg_data_i;
              if (count_q == '0) begin
                next_d = cfg_data_i;
              end
            end
            CFG_HEAP_LIMIT: limit_d = cfg_data_i;
            default: ;  // drop writes past the register list
          endcase
        end
        if (start_i) begin
          state_d = S_WALK;
          idx_d   = '0;
          at_d    = base_q;
          mode_d  = mode_i;
          req_d   = req_size_i;
          addr_d  = address_i;
        end
      end

      S_WALK: begin
        if (!mode_q && (req_q == '0)) begin
          fin        = 1'b1;
          status_d   = ST_ZERO;
          res_addr_d = '0;
        end else if (!in_range) begin
          // Walk exhausted: free misses, alloc appends a new block unless out of memory or the table is full.
          fin        = 1'b1;
          res_addr_d = '0;
          if (mode_q) begin
            status_d = ST_UNKNOWN;
          end else if (oom) begin
            status_d = ST_OOM;
          end else if (count_q == FULL) begin
            status_d = ST_FULL;
          end else begin
            status_d   = ST_OK;
            ram_we     = 1'b1;
            ram_waddr  = count_q[IW-1:0];
            ram_wdata  = {1'b1, req_q};
            count_d    = count_q + 1'b1;
            res_addr_d = next_q + HDR[AW-1:0];
            next_d     = sat_top(next_sum);
            used_d     = sat_top(used_app_sum);
          end
        end else if (!mode_q && alloc_hit) begin
          // Reuse a free block whole, keep its recorded size.
          fin        = 1'b1;
          status_d   = ST_OK;
          ram_we     = 1'b1;
          ram_wdata  = {1'b1, ent_size};
          res_addr_d = pay_addr;
          used_d     = sat_top(used_reuse_sum);
        end else if (mode_q && free_hit) begin
          fin        = 1'b1;
          res_addr_d = '0;
          if (ent_used) begin
            status_d  = ST_OK;
            ram_we    = 1'b1;
            ram_wdata = {1'b0, ent_size};
            used_d    = (rel_len > {2'b00, used_q}) ? '0 : (used_q - rel_len[AW-1:0]);
          end else begin
            status_d = ST_UNKNOWN;
          end
        end else begin
          // Advance to the next header.
          idx_d = idx_q + 1'b1;
          at_d  = at_step;
        end

        if (fin) begin
          state_d = S_IDLE;
          valid_d = 1'b1;
          bytes_d = used_d;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      base_q     <= BASE_RST;
      limit_q    <= LIMIT_RST;
      next_q     <= BASE_RST;
      used_q     <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      at_q       <= '0;
      mode_q     <= 1'b0;
      req_q      <= '0;
      addr_q     <= '0;
      valid_q    <= 1'b0;
      status_q   <= ST_OK;
      res_addr_q <= '0;
      bytes_q    <= '0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      limit_q    <= limit_d;
      next_q     <= next_d;
      used_q     <= used_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      at_q       <= at_d;
      mode_q     <= mode_d;
      req_q      <= req_d;
      addr_q     <= addr_d;
      valid_q    <= valid_d;
      status_q   <= status_d;
      res_addr_q <= res_addr_d;
      bytes_q    <= bytes_d;
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign valid_o          = valid_q;
  assign status_o         = status_q;
  assign result_address_o = res_addr_q;
  assign bytes_used_o     = bytes_q;

endmodule

### sim/ffha_tb_pkg.sv
// ----------------------------------------------------------------------------
// ffha_tb_pkg: reply scoreboard for the first-fit heap allocator testbench
// Mirrors the block table, the address cursor and the used-byte count, and
// queues the reply that each accepted request should produce.
// ----------------------------------------------------------------------------
package ffha_tb_pkg;

  import ffha_pkg::*;

  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned SLOTS    = 256;
  localparam int unsigned BLK_HDR  = 8;
  localparam int unsigned BLK_GAP  = 4;
  localparam int unsigned ERR_SHOW = 100;

  typedef logic [ADDR_W-1:0] haddr_t;

  localparam haddr_t ADDR_MAX    = '1;
  localparam haddr_t RESET_BASE  = 22'd1052672;
  localparam haddr_t RESET_LIMIT = 22'd4063232;

  localparam bit MODE_ALLOC = 1'b0;
  localparam bit MODE_FREE  = 1'b1;

  typedef struct {
    status_e status;
    haddr_t  addr;
    haddr_t  used;
  } heap_reply_t;

  class heap_reply_board;
    haddr_t      base_reg;
    haddr_t      limit_reg;
    haddr_t      next_addr;
    haddr_t      used_bytes;
    haddr_t      blk_size [SLOTS];
    bit          blk_busy [SLOTS];
    int unsigned blk_count;
    heap_reply_t pending_replies [$];
    int unsigned error_count;

    function new();
      base_reg    = RESET_BASE;
      limit_reg   = RESET_LIMIT;
      next_addr   = RESET_BASE;
      used_bytes  = '0;
      blk_count   = 0;
      error_count = 0;
    endfunction

    task report_error(input string what);
      error_count++;
      if (error_count <= ERR_SHOW) $display("ERROR: %s", what);
    endtask

    function haddr_t add_clamped(input haddr_t a, input int unsigned b);
      int unsigned s;
      s = 32'(a) + b;
      return (s > 32'(ADDR_MAX)) ? ADDR_MAX : haddr_t'(s);
    endfunction

    // Payload address of a slot as the walk sees it, from the current base.
    function haddr_t payload_at(input int unsigned idx);
      haddr_t at;
      at = base_reg;
      for (int unsigned i = 0; i < idx; i++)
        at = haddr_t'(32'(at) + BLK_HDR + 32'(blk_size[i]) + BLK_GAP);
      return haddr_t'(32'(at) + BLK_HDR);
    endfunction

    function void apply_config(input logic [CFG_IDX_W-1:0] idx, input haddr_t data);
      if (idx == CFG_HEAP_BASE) begin
        base_reg = data;
        if (blk_count == 0) next_addr = data;
      end else if (idx == CFG_HEAP_LIMIT) begin
        limit_reg = data;
      end
    endfunction

    function void note_request(input bit mode, input haddr_t size, input haddr_t addr);
      heap_reply_t r;
      haddr_t      at;
      bit          done;
      r.status = ST_OK;
      r.addr   = '0;
      at       = base_reg;
      done     = 1'b0;
      if (mode == MODE_ALLOC) begin
        if (size == '0) begin
          r.status = ST_ZERO;
        end else begin
          for (int unsigned i = 0; i < blk_count && !done; i++) begin
            if (!blk_busy[i] && blk_size[i] >= size) begin
              blk_busy[i] = 1'b1;
              used_bytes  = add_clamped(used_bytes, 32'(size) + BLK_HDR);
              r.addr      = haddr_t'(32'(at) + BLK_HDR);
              done        = 1'b1;
            end else begin
              at = haddr_t'(32'(at) + BLK_HDR + 32'(blk_size[i]) + BLK_GAP);
            end
          end
          if (!done) begin
            if (32'(next_addr) + 32'(size) + BLK_HDR >= 32'(limit_reg)) begin
              r.status = ST_OOM;
            end else if (blk_count >= SLOTS) begin
              r.status = ST_FULL;
            end else begin
              blk_size[blk_count] = size;
              blk_busy[blk_count] = 1'b1;
              blk_count++;
              r.addr     = haddr_t'(32'(next_addr) + BLK_HDR);
              next_addr  = add_clamped(next_addr, 32'(size) + BLK_HDR + BLK_GAP);
              used_bytes = add_clamped(used_bytes, 32'(size) + BLK_HDR + BLK_GAP);
            end
          end
        end
      end else begin
        for (int unsigned i = 0; i < blk_count && !done; i++) begin
          if (haddr_t'(32'(at) + BLK_HDR) == addr) begin
            done = 1'b1;
            if (!blk_busy[i]) begin
              r.status = ST_UNKNOWN;
            end else begin
              blk_busy[i] = 1'b0;
              used_bytes  = (32'(blk_size[i]) + BLK_HDR > 32'(used_bytes)) ? '0 :
                            haddr_t'(32'(used_bytes) - 32'(blk_size[i]) - BLK_HDR);
            end
          end else begin
            at = haddr_t'(32'(at) + BLK_HDR + 32'(blk_size[i]) + BLK_GAP);
          end
        end
        if (!done) r.status = ST_UNKNOWN;
      end
      r.used = used_bytes;
      pending_replies.push_back(r);
    endfunction

    task check_reply(input logic [STATUS_W-1:0] st, input haddr_t addr, input haddr_t used);
      heap_reply_t want;
      if (pending_replies.size() == 0) begin
        report_error($sformatf("reply with nothing outstanding: status %0d addr %h used %h",
                               st, addr, used));
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status)
        report_error($sformatf("status %0d, expected %0d (%s)", st, want.status,
                               want.status.name()));
      if (addr !== want.addr)
        report_error($sformatf("result_address %h, expected %h", addr, want.addr));
      if (used !== want.used)
        report_error($sformatf("bytes_used %h, expected %h", used, want.used));
    endtask
  endclass

endpackage

### sim/tb_first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit: request-level test of the heap allocator
// Drives allocate and free commands, programs base and limit between phases,
// and checks every reply strobe against a scoreboard that tracks the table.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;
  import ffha_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Indexes past the register list; writes there must leave the block alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
  // Base near the top of the address space so the walk wraps early.
  localparam haddr_t WRAP_BASE = 22'h3FFF00;
  localparam haddr_t LOW_BASE  = 22'h200000;
  // Larger than any block this test ever appends.
  localparam haddr_t OVERSIZE  = 22'd5000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  logic                 mode_i      = 1'b0;
  haddr_t               req_size_i  = '0;
  haddr_t               address_i   = '0;
  logic                 valid_o;
  logic [STATUS_W-1:0]  status_o;
  haddr_t               result_address_o;
  haddr_t               bytes_used_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  haddr_t               cfg_data_i  = '0;

  heap_reply_board board = new();
  int unsigned     gap_pct = 20;
  int unsigned     cycle_count = 0;

  first_fit_heap_allocator_unit #(
    .MAX_BLOCKS  (SLOTS),
    .HEADER_BYTES(BLK_HDR),
    .GAP_BYTES   (BLK_GAP),
    .ADDR_BITS   (ADDR_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .mode_i          (mode_i),
    .req_size_i      (req_size_i),
    .address_i       (address_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .result_address_o(result_address_o),
    .bytes_used_o    (bytes_used_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: a hung walk or a lost reply ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    board.report_error($sformatf("timeout, %0d replies outstanding",
                                 board.pending_replies.size()));
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Reply monitor: the strobe lasts one cycle and cannot be held off, so
  // take the transfer at every edge where it is high.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && valid_o === 1'b1)
      board.check_reply(status_o, result_address_o, bytes_used_o);
  end

  // Send one request. Idle first with the current gap rate, scrambling the
  // payload while start is low, then hold start until the transfer is taken.
  // Returns at the accepting edge with start still high, so a back-to-back
  // request keeps start up without a dip.
  task automatic issue(input bit mode, input haddr_t size, input haddr_t addr);
    while ($urandom_range(99) < gap_pct) begin
      start_i    <= 1'b0;
      mode_i     <= 1'($urandom);
      req_size_i <= haddr_t'($urandom);
      address_i  <= haddr_t'($urandom);
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    mode_i     <= mode;
    req_size_i <= size;
    address_i  <= addr;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    board.note_request(mode, size, addr);
  endtask

  // Drop start and wait until every outstanding reply has come back; the
  // block drops busy in the reply cycle, so it is idle from here on.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Write one register. Valid stays high so writes can go back to back;
  // the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input haddr_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    board.apply_config(idx, data);
  endtask

  // Random slot that is in use (or free), if any.
  function automatic int unsigned pick_block(input bit want_busy, output bit hit);
    int unsigned cand [$];
    for (int unsigned i = 0; i < board.blk_count; i++)
      if (board.blk_busy[i] == want_busy) cand.push_back(i);
    hit = (cand.size() != 0);
    return hit ? cand[$urandom_range(cand.size() - 1)] : 0;
  endfunction

  // Allocation sizes: aim 45 percent at free blocks (exact fit, smaller, one byte
  // too big) so the first-fit walk has work, plus fresh small and medium
  // sizes, zero, and huge sizes that can never fit above the append cursor.
  function automatic haddr_t draw_alloc_size();
    int unsigned roll;
    int unsigned slot;
    bit          hit;
    roll = $urandom_range(99);
    if (roll < 45) begin
      slot = pick_block(1'b0, hit);
      if (hit) begin
        case ($urandom_range(2))
          0:       return board.blk_size[slot];
          1:       return haddr_t'($urandom_range(board.blk_size[slot], 1));
          default: return board.blk_size[slot] + 1'b1;
        endcase
      end
      return haddr_t'($urandom_range(64, 1));
    end
    if (roll < 80) return haddr_t'($urandom_range(64, 1));
    if (roll < 90) return haddr_t'($urandom_range(4096, 65));
    if (roll < 95) return '0;
    return haddr_t'(32'h3C0000 | $urandom_range(32'h3FFFF, 0));
  endfunction

  // Free addresses: mostly live blocks, then double frees, addresses just
  // off a payload, and raw noise.
  function automatic haddr_t draw_free_address();
    int unsigned roll;
    int unsigned slot;
    bit          hit;
    roll = $urandom_range(99);
    if (roll < 70) begin
      slot = pick_block(1'b1, hit);
      if (hit) return board.payload_at(slot);
    end else if (roll < 82) begin
      slot = pick_block(1'b0, hit);
      if (hit) return board.payload_at(slot);
    end else if (roll < 90) begin
      slot = pick_block(1'($urandom), hit);
      if (hit) return board.payload_at(slot) + 3'd4;
    end
    return haddr_t'($urandom);
  endfunction

  task automatic run_random(input int unsigned n_items, input int unsigned alloc_pct);
    bit     mode;
    haddr_t size;
    haddr_t addr;
    for (int unsigned k = 0; k < n_items; k++) begin
      mode = ($urandom_range(99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
      if (mode == MODE_ALLOC) begin
        size = draw_alloc_size();
        addr = haddr_t'($urandom);
      end else begin
        size = haddr_t'($urandom);
        addr = draw_free_address();
      end
      issue(mode, size, addr);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part, sender idles with a gap rate of 20 percent ----
    gap_pct = 20;
    // Registers at reset: free on an empty table, zero size, size too big.
    issue(MODE_FREE, ADDR_MAX, haddr_t'(32'(RESET_BASE) + BLK_HDR));
    issue(MODE_ALLOC, '0, ADDR_MAX);
    issue(MODE_ALLOC, ADDR_MAX, '0);

    // Base written with the table empty: the append cursor follows it.
    wait_drained();
    write_reg(CFG_HEAP_BASE, LOW_BASE);
    cfg_valid_i <= 1'b0;

    issue(MODE_ALLOC, 22'd100, '0);                    // append slot 0
    issue(MODE_FREE, '0, board.payload_at(0));         // free it
    issue(MODE_FREE, '0, board.payload_at(0));         // double free
    issue(MODE_ALLOC, 22'd50, '0);                     // reuse, counts 50 plus header, not 100
    issue(MODE_FREE, '0, board.payload_at(0));         // used count floors at zero
    issue(MODE_ALLOC, 22'd1, '0);                      // reuses free slot 0
    issue(MODE_ALLOC, 22'd200, '0);                    // append slot 1
    issue(MODE_ALLOC, 22'd100, '0);                    // append slot 2, slot 0 is taken
    issue(MODE_ALLOC, 22'd150, '0);                    // append slot 3
    issue(MODE_FREE, '0, board.payload_at(1));
    issue(MODE_FREE, '0, board.payload_at(2));
    issue(MODE_ALLOC, 22'd1, '0);                      // first fit picks slot 1
    issue(MODE_ALLOC, 22'd199, '0);                    // too big for slot 2, append slot 4
    issue(MODE_FREE, '0, board.payload_at(0) + 3'd4);  // not a payload address

    // Limit just above the cursor: size 10 reuses free slot 2, size 9 appends below it.
    // Writes to the spare indexes must not touch the limit.
    wait_drained();
    write_reg(CFG_HEAP_LIMIT, haddr_t'(32'(board.next_addr) + BLK_HDR + 10));
    write_reg(CFG_IDX_SPARE2, ADDR_MAX);
    write_reg(CFG_IDX_SPARE3, ADDR_MAX);
    cfg_valid_i <= 1'b0;
    issue(MODE_ALLOC, 22'd10, ADDR_MAX);
    issue(MODE_ALLOC, 22'd9, ADDR_MAX);

    // Limit at zero: appends fail, reuse of a freed block still works.
    wait_drained();
    write_reg(CFG_HEAP_LIMIT, '0);
    cfg_valid_i <= 1'b0;
    issue(MODE_ALLOC, 22'd1, '0);
    issue(MODE_FREE, '0, board.payload_at(3));
    issue(MODE_ALLOC, 22'd150, '0);

    // ---- Random phase 1: base moved to zero under a live table ----
    wait_drained();
    write_reg(CFG_HEAP_BASE, '0);
    write_reg(CFG_HEAP_LIMIT, ADDR_MAX);
    cfg_valid_i <= 1'b0;
    gap_pct = 20;
    run_random(90, 55);

    // ---- Random phase 2: reset values back, sender mostly idle ----
    wait_drained();
    write_reg(CFG_HEAP_BASE, RESET_BASE);
    write_reg(CFG_HEAP_LIMIT, RESET_LIMIT);
    cfg_valid_i <= 1'b0;
    gap_pct = 88;
    run_random(50, 50);

    // ---- Random phase 3: walk wraps past the top, no idling ----
    wait_drained();
    write_reg(CFG_HEAP_BASE, WRAP_BASE);
    write_reg(CFG_HEAP_LIMIT, ADDR_MAX);
    cfg_valid_i <= 1'b0;
    gap_pct = 0;
    run_random(90, 70);

    // Fill the table, then check that the memory check wins over the
    // table-full check, and that a fitting append reports a full table.
    while (board.blk_count < SLOTS) issue(MODE_ALLOC, haddr_t'($urandom_range(32, 1)), '0);
    issue(MODE_ALLOC, ADDR_MAX, '0);
    issue(MODE_ALLOC, OVERSIZE, '0);

    // Base at the very top: every walk address wraps at once.
    wait_drained();
    write_reg(CFG_HEAP_BASE, ADDR_MAX);
    cfg_valid_i <= 1'b0;
    run_random(25, 50);
    issue(MODE_ALLOC, OVERSIZE, '0);

    // Let any stray reply show up before the verdict.
    wait_drained();
    repeat (SLOTS + 2) @(posedge clk_i);
    if (board.pending_replies.size() != 0)
      board.report_error($sformatf("%0d replies never arrived", board.pending_replies.size()));
    if (board.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
